>>> src/cross_entropy_loss_accumulator_core_assert.svh
// Assertion macros for the loss accumulator.
// CELACC_ASSERT     : property checked every edge outside reset.
// CELACC_ASSERT_RST : property checked on the edge after a reset edge.
`ifndef CROSS_ENTROPY_LOSS_ACCUMULATOR_CORE_ASSERT_SVH
`define CROSS_ENTROPY_LOSS_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define CELACC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CELACC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);
`else
`define CELACC_ASSERT(lbl, clk, rstn, prop, msg)
`define CELACC_ASSERT_RST(lbl, clk, rstn, prop, msg)
`endif
`endif

>>> src/celacc_pkg.sv
package celacc_pkg;

  localparam int unsigned LOG_TABLE_BITS = 8;
  localparam int unsigned TBL_N          = 1 << LOG_TABLE_BITS;

  localparam int unsigned SUM_W  = 48;
  localparam int unsigned L2_W   = 21;
  localparam int unsigned LN_W   = 20;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned PROD_W = 64;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  // one closed position on its way to the scaling stage
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [15:0]      wgt;
  } pos_t;

  // log2(1 + idx/2^LOG_TABLE_BITS) in Q0.16; elaboration only
  function automatic logic [FRAC_W-1:0] log2_frac_q16(input int unsigned idx);
    logic [63:0] v;
    logic [23:0] r;
    logic [24:0] rr;
    v = (64'd1 << 30) + (64'(idx) << (30 - LOG_TABLE_BITS));
    r = '0;
    for (int k = 0; k < 24; k++) begin
      v = (v * v) >> 30;
      r = {r[22:0], 1'b0};
      if (v >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        v    = v >> 1;
      end
    end
    rr = {1'b0, r} + 25'd128;
    return rr[24:8];
  endfunction

endpackage

>>> src/celacc_fifo.sv
module celacc_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

>>> src/celacc_front.sv
module celacc_front #(
  parameter int unsigned MID_DEPTH = celacc_pkg::MID_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [15:0]                    in_predicted_prob,
  input  logic [15:0]                    in_target_prob,
  input  logic [15:0]                    in_position_weight,
  input  logic                           in_last_class,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  output logic                           mid_push,
  output celacc_pkg::pos_t               mid_rec
);

  import celacc_pkg::*;

  localparam int unsigned CW = $clog2(MID_DEPTH+1);
  localparam int unsigned TB = LOG_TABLE_BITS;

  // constant log table, built at elaboration
  logic [FRAC_W-1:0] log_tbl [TBL_N];
  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    localparam logic [FRAC_W-1:0] FRAC = log2_frac_q16(g);
    assign log_tbl[g] = FRAC;
  end

  logic          accept;
  logic [CW-1:0] inflight_r;

  // stage a: registered word
  logic          a_vld_r, a_last_r;
  logic [15:0]   a_pred_r, a_targ_r, a_wgt_r;
  // stage b: exponent and mantissa index
  logic          b_vld_r, b_last_r;
  logic [15:0]   b_targ_r, b_wgt_r;
  logic [3:0]    b_exp_r;
  logic [TB-1:0] b_idx_r;
  // stage c: -log2 p
  logic            c_vld_r, c_last_r;
  logic [15:0]     c_targ_r, c_wgt_r;
  logic [L2_W-1:0] c_l2_r;
  // stage d: -ln p
  logic            d_vld_r, d_last_r;
  logic [15:0]     d_targ_r, d_wgt_r;
  logic [LN_W-1:0] d_ln_r;
  // stage e: weighted term
  logic            e_vld_r, e_last_r;
  logic [15:0]     e_wgt_r;
  logic [LN_W-1:0] e_term_r;

  logic [SUM_W-1:0] sum_r;

  logic [15:0]      p_fix;
  logic [3:0]       exp_nxt;
  logic [15:0]      norm;
  logic [TB-1:0]    idx_nxt;
  logic [L2_W-1:0]  l2_nxt;
  logic [36:0]      ln_full;
  logic [35:0]      term_full;
  logic [SUM_W:0]   acc;
  logic [SUM_W-1:0] sum_nxt;

  assign in_full = ({1'b0, mid_count} + {1'b0, inflight_r}) >= (CW+1)'(MID_DEPTH);
  assign accept  = in_push && !in_full;

  // leading one and normalise
  always_comb begin
    p_fix   = (a_pred_r == 16'd0) ? 16'd1 : a_pred_r;
    exp_nxt = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (p_fix[i]) begin
        exp_nxt = 4'(i);
      end
    end
    norm    = p_fix << (4'd15 - exp_nxt);
    idx_nxt = norm[14 -: TB];
  end

  assign l2_nxt    = {5'd16 - {1'b0, b_exp_r}, 16'd0} - L2_W'(log_tbl[b_idx_r]);
  assign ln_full   = 37'(c_l2_r) * 37'(LN2_Q16) + 37'd32768;
  assign term_full = 36'(d_targ_r) * 36'(d_ln_r) + 36'd32768;

  // zero targets give a zero term, so no bypass
  assign acc     = {1'b0, sum_r} + (SUM_W+1)'(e_term_r);
  assign sum_nxt = acc[SUM_W] ? '1 : acc[SUM_W-1:0];

  assign mid_push    = e_vld_r && e_last_r;
  assign mid_rec.sum = sum_nxt;
  assign mid_rec.wgt = e_wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      d_vld_r    <= 1'b0;
      e_vld_r    <= 1'b0;
      sum_r      <= '0;
      inflight_r <= '0;
    end else begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      if (e_vld_r) begin
        sum_r <= e_last_r ? '0 : sum_nxt;
      end
      if ((accept && in_last_class) && !mid_push) begin
        inflight_r <= inflight_r + 1'b1;
      end else if (mid_push && !(accept && in_last_class)) begin
        inflight_r <= inflight_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_last_r <= in_last_class;
    a_pred_r <= in_predicted_prob;
    a_targ_r <= in_target_prob;
    a_wgt_r  <= in_position_weight;
    b_last_r <= a_last_r;
    b_targ_r <= a_targ_r;
    b_wgt_r  <= a_wgt_r;
    b_exp_r  <= exp_nxt;
    b_idx_r  <= idx_nxt;
    c_last_r <= b_last_r;
    c_targ_r <= b_targ_r;
    c_wgt_r  <= b_wgt_r;
    c_l2_r   <= l2_nxt;
    d_last_r <= c_last_r;
    d_targ_r <= c_targ_r;
    d_wgt_r  <= c_wgt_r;
    d_ln_r   <= ln_full[LN_W+15:16];
    e_last_r <= d_last_r;
    e_wgt_r  <= d_wgt_r;
    e_term_r <= term_full[LN_W+15:16];
  end

endmodule

>>> src/celacc_back.sv
module celacc_back #(
  parameter int unsigned MID_DEPTH = celacc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = celacc_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [15:0]             loss_scale,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  input  celacc_pkg::pos_t               mid_rec,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output logic [31:0]                    out_word
);

  import celacc_pkg::*;

  localparam int unsigned OCW = $clog2(OUT_DEPTH+1);

  logic [1:0]       busy_cnt;
  logic [15:0]      sc_abs;
  logic [31:0]      mag_full;

  // m1: |scale| * weight
  logic             m1_vld_r, m1_neg_r;
  logic [SUM_W-1:0] m1_sum_r;
  logic [MAG_W-1:0] m1_mag_r;
  // m2: partial products
  logic             m2_vld_r, m2_neg_r, m2_big_r;
  logic [62:0]      m2_plo_r;
  logic [31:0]      m2_phi_r;
  // m3: full product
  logic              m3_vld_r, m3_neg_r, m3_big_r;
  logic [PROD_W-1:0] m3_prod_r;

  logic [PROD_W:0] rnd;
  logic [47:0]     res;
  logic [31:0]     lim;
  logic [31:0]     res_sat;

  assign busy_cnt = 2'(m1_vld_r) + 2'(m2_vld_r) + 2'(m3_vld_r);
  assign mid_pop  = (mid_count != '0) &&
                    ((OCW+2)'(out_count) + (OCW+2)'(busy_cnt) < (OCW+2)'(OUT_DEPTH));

  assign sc_abs   = loss_scale[15] ? 16'(~loss_scale) + 16'd1 : loss_scale;
  assign mag_full = 32'(sc_abs) * 32'(mid_rec.wgt);

  // round, saturate, apply sign
  assign rnd      = (PROD_W+1)'(m3_prod_r) + (PROD_W+1)'(32768);
  assign res      = rnd[63:16];
  assign lim      = m3_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign res_sat  = (m3_big_r || (res > 48'(lim))) ? lim : res[31:0];
  assign out_word = m3_neg_r ? 32'(~res_sat) + 32'd1 : res_sat;
  assign out_push = m3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= mid_pop;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_neg_r  <= loss_scale[15];
    m1_sum_r  <= mid_rec.sum;
    m1_mag_r  <= mag_full[MAG_W-1:0];
    m2_neg_r  <= m1_neg_r;
    // both upper halves set: product is past any 32-bit result
    m2_big_r  <= (|m1_sum_r[47:32]) && (|m1_mag_r[30:16]);
    m2_plo_r  <= 63'(m1_sum_r[31:0]) * 63'(m1_mag_r);
    m2_phi_r  <= 32'(m1_sum_r[47:32]) * 32'(m1_mag_r[15:0]);
    m3_neg_r  <= m2_neg_r;
    m3_big_r  <= m2_big_r;
    m3_prod_r <= {m2_phi_r, 32'd0} + PROD_W'(m2_plo_r);
  end

endmodule

>>> src/cross_entropy_loss_accumulator_core.sv
// chan  dir  handshake              word
// in    in   in_push / in_full      predicted, target, position weight, last flag
// out   out  out_pop / out_empty    loss_value, signed Q16.16
// cfg   in   cfg_valid / cfg_ready  loss_scale, signed Q8.8
//
// One class word per cycle at the input while in_full is low; from acceptance to
// the mid queue a word passes normalise, table, ln2 multiply, target multiply, accumulate.
// A closed position leaving the mid queue passes scale multiply, partial products,
// full product, and round and saturate on its way to the output queue.
// Reset is synchronous: queues empty, sum cleared, loss_scale back to 1.0.
// in_full rises when queued plus in-flight positions fill the mid queue.
`include "cross_entropy_loss_accumulator_core_assert.svh"

module cross_entropy_loss_accumulator_core #(
  parameter int unsigned MID_DEPTH = celacc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = celacc_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_predicted_prob,
  input  logic [15:0]        in_target_prob,
  input  logic [15:0]        in_position_weight,
  input  logic               in_last_class,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_loss_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_loss_scale
);

  import celacc_pkg::*;

  localparam int unsigned MID_CW = $clog2(MID_DEPTH+1);
  localparam int unsigned OUT_CW = $clog2(OUT_DEPTH+1);

  // global loss weight, Q8.8; user writes it only while idle, block does not enforce it
  logic signed [15:0] loss_scale_r;

  // front to back: closed positions
  logic              mid_push;
  logic              mid_pop;
  pos_t              mid_in;
  pos_t              mid_head;
  logic [MID_CW-1:0] mid_count;

  // back to output queue
  logic              out_push;
  logic [31:0]       out_word;
  logic [OUT_CW-1:0] out_count;
  logic              out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_scale_r <= 16'sd256;
    end else if (cfg_valid && cfg_ready) begin
      loss_scale_r <= cfg_loss_scale;
    end
  end

  // front end: log, target weighting, per-position sum
  celacc_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_predicted_prob  (in_predicted_prob),
    .in_target_prob     (in_target_prob),
    .in_position_weight (in_position_weight),
    .in_last_class      (in_last_class),
    .mid_count          (mid_count),
    .mid_push           (mid_push),
    .mid_rec            (mid_in)
  );

  // decoupling queue; front reserves a slot per closing word in flight
  celacc_fifo #(
    .WIDTH ($bits(pos_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (mid_pop),
    .rdata (mid_head),
    .count (mid_count)
  );

  // back end: scale by loss_scale * position weight, round, saturate
  celacc_back #(
    .MID_DEPTH (MID_DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .loss_scale (loss_scale_r),
    .mid_count  (mid_count),
    .mid_rec    (mid_head),
    .mid_pop    (mid_pop),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_word   (out_word)
  );

  // result queue; head word sits on the output ports
  celacc_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_word),
    .pop   (out_take),
    .rdata (out_loss_value),
    .count (out_count)
  );

  assign out_empty = (out_count == '0);
  assign out_take  = out_pop && !out_empty;

  `CELACC_ASSERT(a_mid_room, clk, rst_n, mid_push |-> (mid_count != MID_CW'(MID_DEPTH)), "mid queue overrun")
  `CELACC_ASSERT(a_mid_pop, clk, rst_n, mid_pop |-> (mid_count != '0), "mid queue underrun")
  `CELACC_ASSERT(a_out_room, clk, rst_n, out_push |-> (out_count != OUT_CW'(OUT_DEPTH)), "output queue overrun")
  `CELACC_ASSERT_RST(a_rst_idle, clk, rst_n, out_empty && !in_full, "not idle after reset")

endmodule

>>> dv/tb_cross_entropy_loss_accumulator_core.sv
`timescale 1ns / 1ps

module tb_cross_entropy_loss_accumulator_core;

  localparam int TBL_BITS      = celacc_pkg::LOG_TABLE_BITS;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 30;
  localparam int PHASE_WORDS   = 220;
  localparam int N_PHASES      = 9;
  localparam int N_DIR         = 18;
  localparam logic [63:0] SUM_CAP = (64'd1 << celacc_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    logic [15:0] predicted;
    logic [15:0] target;
    logic [15:0] weight;
    logic        last;
  } class_word_t;

  typedef struct packed {
    logic signed [15:0] scale;
    class_word_t        word;
    bit                 typed;
    logic signed [31:0] loss;
  } dir_row_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_ALTERNATE} pop_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [15:0]        in_predicted_prob = '0;
  logic [15:0]        in_target_prob = '0;
  logic [15:0]        in_position_weight = '0;
  logic               in_last_class = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_loss_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [15:0] cfg_loss_scale = '0;

  // predictor state
  logic [63:0]        sum_acc = '0;
  logic signed [15:0] scale_now = 16'sd256;
  logic signed [31:0] pending_losses [$];

  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b0;
  int        burst_left = 0;
  logic      hold_req = 1'b0;
  logic      hold_done;
  int        hold_cnt;
  int        mode_cnt;
  pop_mode_e pop_mode;

  // directed words; typed-in losses only where the value is plain
  dir_row_t dir_rows [N_DIR] = '{
    '{16'sd256,   '{16'd32768, 16'd65535, 16'd256,   1'b1}, 1'b1, 32'sd45425},
    '{16'sd256,   '{16'd0,     16'd0,     16'd256,   1'b1}, 1'b1, 32'sd0},
    '{16'sd256,   '{16'd0,     16'd65535, 16'd0,     1'b1}, 1'b1, 32'sd0},
    '{16'sd256,   '{16'd0,     16'd65535, 16'd256,   1'b1}, 1'b1, 32'sd726805},
    '{16'sd256,   '{16'd65535, 16'd65535, 16'd256,   1'b0}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'd1,     16'd1,     16'd0,     1'b0}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'd255,   16'd32768, 16'd65535, 1'b1}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'd32768, 16'd0,     16'd256,   1'b0}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'd255,   16'd65535, 16'd123,   1'b0}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'd256,   16'h1234,  16'd65535, 1'b1}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'h4000,  16'd1,     16'd256,   1'b0}, 1'b0, 32'sd0},
    '{16'sd256,   '{16'h7FFF,  16'hAAAA,  16'h5555,  1'b1}, 1'b0, 32'sd0},
    '{16'sd32767, '{16'd0,     16'd65535, 16'd65535, 1'b1}, 1'b1, 32'sh7FFFFFFF},
    '{16'sh8000,  '{16'd0,     16'd65535, 16'd65535, 1'b1}, 1'b1, 32'sh80000000},
    '{16'sh8000,  '{16'd32768, 16'd65535, 16'd256,   1'b1}, 1'b1, -32'sd5814400},
    '{16'sd0,     '{16'd0,     16'd65535, 16'd65535, 1'b1}, 1'b1, 32'sd0},
    '{-16'sd1,    '{16'd1234,  16'd999,   16'd300,   1'b1}, 1'b0, 32'sd0},
    '{16'sd1,     '{16'd0,     16'd65535, 16'd1,     1'b1}, 1'b0, 32'sd0}
  };

  logic signed [15:0] phase_scales [N_PHASES] = '{
    16'sd256, 16'sd32767, 16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sd0, -16'sd256, 16'sd128
  };

  cross_entropy_loss_accumulator_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_predicted_prob  (in_predicted_prob),
    .in_target_prob     (in_target_prob),
    .in_position_weight (in_position_weight),
    .in_last_class      (in_last_class),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_loss_value     (out_loss_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_loss_scale     (cfg_loss_scale)
  );

  always #4 clk = ~clk;

  // log2(1 + idx/2^TBL_BITS) in Q0.16, by repeated squaring
  function automatic logic [16:0] log2_mant_q16(input logic [TBL_BITS-1:0] frac_idx);
    logic [63:0] sq;
    logic [23:0] bits_acc;
    logic [24:0] rounded;
    int n;
    sq = (64'd1 << 30) + (64'(frac_idx) << (30 - TBL_BITS));
    bits_acc = '0;
    for (n = 0; n < 24; n++) begin
      sq = (sq * sq) >> 30;
      bits_acc = bits_acc << 1;
      if (sq >= (64'd2 << 30)) begin
        bits_acc[0] = 1'b1;
        sq = sq >> 1;
      end
    end
    rounded = {1'b0, bits_acc} + 25'd128;
    return rounded[24:8];
  endfunction

  // -ln(p) in Q4.16, p of zero taken as one LSB
  function automatic logic [19:0] neg_ln_q16(input logic [15:0] p);
    logic [15:0] pp;
    logic [15:0] mant;
    logic [31:0] idx_w;
    logic [63:0] l2;
    logic [63:0] prod;
    int lead;
    pp = (p == 16'd0) ? 16'd1 : p;
    lead = 15;
    while (lead > 0 && !pp[lead]) lead--;
    mant = pp ^ (16'd1 << lead);
    if (lead >= TBL_BITS) idx_w = 32'(mant) >> (lead - TBL_BITS);
    else idx_w = 32'(mant) << (TBL_BITS - lead);
    l2 = (64'(16 - lead) << 16) - 64'(log2_mant_q16(idx_w[TBL_BITS-1:0]));
    prod = l2 * 64'(celacc_pkg::LN2_Q16) + 64'd32768;
    return prod[35:16];
  endfunction

  // folds one class word into the running sum; closes the position on last
  task automatic account_word(input class_word_t w, output bit has_res,
                              output logic signed [31:0] loss);
    logic [63:0] term, mag, hi, lo, res, pos_sum;
    bit neg;
    has_res = 1'b0;
    loss = '0;
    if (w.target != 16'd0) begin
      term = (64'(w.target) * 64'(neg_ln_q16(w.predicted)) + 64'd32768) >> 16;
      sum_acc = sum_acc + term;
      if (sum_acc > SUM_CAP) sum_acc = SUM_CAP;
    end
    if (!w.last) return;
    has_res = 1'b1;
    pos_sum = sum_acc;
    sum_acc = '0;
    neg = scale_now < 0;
    mag = 64'(neg ? -int'(scale_now) : int'(scale_now)) * 64'(w.weight);
    if (mag == 0 || pos_sum == 0) return;
    hi = mag >> 16;
    lo = mag & 64'hFFFF;
    // a large sum against a |scale| * weight of 1.0 or more cannot fit
    if (hi != 0 && pos_sum >= 64'h1_0000_0000) res = 64'd1 << 40;
    else res = pos_sum * hi + ((pos_sum * lo + 64'd32768) >> 16);
    if (neg) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      loss = 32'(64'd0 - res);
    end else begin
      if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
      loss = res[31:0];
    end
  endtask

  function automatic class_word_t random_word(input logic last);
    class_word_t w;
    case ($urandom_range(0, 5))
      0:       w.predicted = 16'd0;
      1:       w.predicted = 16'hFFFF;
      2:       w.predicted = 16'($urandom_range(1, 255));
      3:       w.predicted = 16'($urandom) >> $urandom_range(0, 15);
      default: w.predicted = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    w.target = 16'd0;
      2:       w.target = 16'hFFFF;
      default: w.target = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: w.weight = 16'd256;
      3:       w.weight = 16'd0;
      4:       w.weight = 16'hFFFF;
      default: w.weight = 16'($urandom);
    endcase
    w.last = last;
    return w;
  endfunction

  // offers one word until taken, then books its loss if it closes a position
  task automatic send_word(input class_word_t w, input bit typed,
                           input logic signed [31:0] typed_loss);
    bit has_res;
    logic signed [31:0] loss;
    if (gaps_on && burst_left <= 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_push            <= 1'b1;
    in_predicted_prob  <= w.predicted;
    in_target_prob     <= w.target;
    in_position_weight <= w.weight;
    in_last_class      <= w.last;
    do @(posedge clk); while (in_full);
    burst_left--;
    account_word(w, has_res, loss);
    if (has_res) pending_losses.push_back(typed ? typed_loss : loss);
  endtask

  // loss_scale only changes with nothing in flight
  task automatic write_scale(input logic signed [15:0] value);
    in_push <= 1'b0;
    while (pending_losses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_loss_scale <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_now = value;
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop   <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
      mode_cnt  <= 0;
      pop_mode  <= POP_ALWAYS;
    end else begin
      if (mode_cnt == 0) begin
        pop_mode <= pop_mode_e'($urandom_range(0, 3));
        mode_cnt <= $urandom_range(32, 400);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      if (hold_cnt != 0) begin
        out_pop  <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (hold_req && !hold_done) begin
        out_pop   <= 1'b0;
        hold_cnt  <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        case (pop_mode)
          POP_ALWAYS:  out_pop <= 1'b1;
          POP_MOSTLY:  out_pop <= ($urandom_range(0, 3) != 0);
          POP_RARELY:  out_pop <= ($urandom_range(0, 3) == 0);
          default:     out_pop <= ~out_pop;
        endcase
      end
    end
  end

  // result check against the oldest booked loss
  always @(posedge clk) begin : loss_check
    logic signed [31:0] want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_losses.size() == 0) begin
        $error("loss_value: no word expected, actual %0d", out_loss_value);
        fail_count++;
      end else begin
        want = pending_losses.pop_front();
        if (out_loss_value !== want) begin
          $error("loss_value: expected %0d, actual %0d", want, out_loss_value);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL cross_entropy_loss_accumulator_core");
        $finish;
      end
    end
  end

  initial begin : stimulus
    class_word_t w;
    logic signed [15:0] next_scale;
    int ph, k, n, sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: extremes, zero target, zero predicted, saturation
    gaps_on = 1'b1;
    for (k = 0; k < N_DIR; k++) begin
      if (dir_rows[k].scale != scale_now) write_scale(dir_rows[k].scale);
      send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].loss);
    end

    // random positions, one loss_scale per phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      next_scale = (ph == 6) ? 16'($urandom) : phase_scales[ph];
      write_scale(next_scale);
      gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // back-to-back single-word positions against a held-off receiver
        hold_req <= 1'b1;
        gaps_on = 1'b0;
        for (k = 0; k < 48; k++) send_word(random_word(1'b1), 1'b0, '0);
        gaps_on = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          w = random_word(k == n - 1);
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
    end

    in_push <= 1'b0;
    while (pending_losses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS cross_entropy_loss_accumulator_core");
    else
      $display("FAIL cross_entropy_loss_accumulator_core");
    $finish;
  end

endmodule
